// File: rtl/scvh_pkg.sv
// ----------------------------------------------------------------------------
// scvh_pkg
// Shared types and codes of the simple polygon convex hull block.
// ----------------------------------------------------------------------------
package scvh_pkg;

  // Kind of work an accepted beat asks for
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_WALK,
    OP_READ
  } scvh_op_e;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_OVF   = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;
  localparam logic [1:0] STAT_SHORT = 2'd3;

  // Back end sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_W0,
    S_MIN0,
    S_MIN,
    S_PRV0,
    S_PRV1,
    S_MV_RD,
    S_MV_WR,
    S_DULL,
    S_INIT,
    S_CHK,
    S_P1,
    S_P1R,
    S_POP,
    S_POPW,
    S_B,
    S_BR,
    S_C,
    S_CR,
    S_D,
    S_FIN,
    S_LA,
    S_LB,
    S_LC,
    S_LD,
    S_LM,
    S_LE,
    S_OUT
  } scvh_state_e;

endpackage

// File: rtl/scvh_front.sv
// ----------------------------------------------------------------------------
// scvh_front
// Accepts input beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module scvh_front #(
  parameter int CW = 16,
  parameter int IW = 11
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_valid_i,
  output logic                    s_ready_o,
  input  logic                    s_mode_i,
  input  logic                    s_last_i,
  input  logic [CW-1:0]           s_x_i,
  input  logic [CW-1:0]           s_y_i,
  input  logic [IW-1:0]           s_pos_i,
  output logic                    q_valid_o,
  input  logic                    q_ready_i,
  output scvh_pkg::scvh_op_e      q_kind_o,
  output logic [CW-1:0]           q_x_o,
  output logic [CW-1:0]           q_y_o,
  output logic [IW-1:0]           q_pos_o
);

  scvh_pkg::scvh_op_e kind_q [2];
  logic [CW-1:0]      x_q    [2];
  logic [CW-1:0]      y_q    [2];
  logic [IW-1:0]      pos_q  [2];
  logic               wp_q, rp_q;
  logic [1:0]         cnt_q;
  scvh_pkg::scvh_op_e kind;
  logic               push, pop;

  // Classify the beat
  always_comb begin
    if (s_mode_i) begin
      kind = scvh_pkg::OP_READ;
    end else if (s_last_i) begin
      kind = scvh_pkg::OP_WALK;
    end else begin
      kind = scvh_pkg::OP_LOAD;
    end
  end

  assign s_ready_o = (cnt_q != 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign push      = s_valid_i & s_ready_o;
  assign pop       = q_valid_o & q_ready_i;
  assign q_kind_o  = kind_q[rp_q];
  assign q_x_o     = x_q[rp_q];
  assign q_y_o     = y_q[rp_q];
  assign q_pos_o   = pos_q[rp_q];

  // Advance queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // Hold queued payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      kind_q[wp_q] <= kind;
      x_q[wp_q]    <= s_x_i;
      y_q[wp_q]    <= s_y_i;
      pos_q[wp_q]  <= s_pos_i;
    end
  end

endmodule

// File: rtl/scvh_back.sv
// ----------------------------------------------------------------------------
// scvh_back
// Executes loads, the hull walk and hull reads over the vertex and stack
// memories, and holds the result beat in an output register.
// ----------------------------------------------------------------------------
module scvh_back #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 16,
  parameter int IW           = 11
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [9:0]              tol_i,
  input  logic                    q_valid_i,
  output logic                    q_ready_o,
  input  scvh_pkg::scvh_op_e      q_kind_i,
  input  logic [COORD_BITS-1:0]   q_x_i,
  input  logic [COORD_BITS-1:0]   q_y_i,
  input  logic [IW-1:0]           q_pos_i,
  output logic                    m_valid_o,
  input  logic                    m_ready_i,
  output logic [IW-1:0]           m_count_o,
  output logic [COORD_BITS-1:0]   m_x_o,
  output logic [COORD_BITS:0]     m_y_o,
  output logic [IW-1:0]           m_num_o,
  output logic                    m_dull_o,
  output logic [1:0]              m_status_o
);

  localparam int CW  = COORD_BITS;
  localparam int YW  = COORD_BITS + 1;
  localparam int EW  = COORD_BITS + 2;
  localparam int PW  = 2 * EW;
  localparam int DW  = COORD_BITS + 3;
  localparam int SD  = MAX_VERTICES + 1;
  localparam int KD  = MAX_VERTICES + 4;
  localparam int SAW = $clog2(SD);
  localparam int KAW = $clog2(KD);
  localparam int BW  = $clog2(3 * MAX_VERTICES + 12);

  // Memories
  logic signed [CW-1:0] vx_mem [SD];
  logic signed [YW-1:0] vy_mem [SD];
  logic [IW-1:0]        hmem   [KD];

  logic                 vwe, hwe;
  logic [SAW-1:0]       vwa, vra;
  logic signed [CW-1:0] vwx;
  logic signed [YW-1:0] vwy;
  logic [KAW-1:0]       hwa, hra;
  logic [IW-1:0]        hwd;
  logic signed [CW-1:0] vrd_x_q;
  logic signed [YW-1:0] vrd_y_q;
  logic [IW-1:0]        hrd_q;

  scvh_pkg::scvh_state_e state_q, state_d, ret_q, ret_d, pret_q, pret_d;
  logic [IW-1:0] cnt_q, cnt_d, hdepth_q, hdepth_d, start_q, start_d;
  logic          dull_q, dull_d, ov_q, ov_d;
  logic [IW-1:0] n_q, n_d, s_q, s_d, i_q, i_d, prev_q, prev_d, val_q, val_d;
  logic [IW-1:0] d_q, d_d, top_q, top_d, sec_q, sec_d, thd_q, thd_d, s1_q, s1_d;
  logic [IW-1:0] p_q, p_d, r1_q, r1_d, r2_q, r2_d, v_q, v_d;
  logic [1:0]    k_q, k_d;
  logic [BW-1:0] bud_q, bud_d;
  logic signed [CW-1:0] sx_q, sx_d, ax_q, ax_d, bx_q, bx_d;
  logic signed [YW-1:0] sy_q, sy_d, ay_q, ay_d, by_q, by_d;
  logic signed [DW-1:0] y0_q, y0_d, dif, adif;
  logic signed [EW-1:0] e1_q, e1_d, e2_q, e2_d, e3_q, e3_d, e4_q, e4_d;
  logic signed [PW-1:0] m1_q, m1_d, m2_q, m2_d;
  logic          lt_q, lt_d;
  logic signed [CW-1:0] rx_q, rx_d;
  logic signed [YW-1:0] ry_q, ry_d;
  logic [IW-1:0] rnum_q, rnum_d;
  logic          rdull_q, rdull_d;
  logic [1:0]    rst_q, rst_d;
  logic [IW-1:0] oc_q, oc_d, on_q, on_d;
  logic [CW-1:0] ox_q, ox_d;
  logic [YW-1:0] oy_q, oy_d;
  logic          odull_q, odull_d;
  logic [1:0]    ost_q, ost_d;
  logic [IW-1:0] top_inc, sec_dec;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] v, input logic [IW-1:0] n);
    idx_inc = (v == n - IW'(1)) ? '0 : v + IW'(1);
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] v, input logic [IW-1:0] n);
    idx_dec = (v == '0) ? n - IW'(1) : v - IW'(1);
  endfunction

  assign top_inc = idx_inc(top_q, n_q);
  assign sec_dec = idx_dec(sec_q, n_q);
  assign dif     = DW'(vrd_y_q) - y0_q;
  assign adif    = (dif < 0) ? -dif : dif;

  assign m_valid_o  = ov_q;
  assign m_count_o  = oc_q;
  assign m_x_o      = ox_q;
  assign m_y_o      = oy_q;
  assign m_num_o    = on_q;
  assign m_dull_o   = odull_q;
  assign m_status_o = ost_q;

  // Next state and datapath
  always_comb begin
    state_d = state_q; ret_d = ret_q; pret_d = pret_q;
    cnt_d = cnt_q; hdepth_d = hdepth_q; start_d = start_q; dull_d = dull_q;
    ov_d = ov_q & ~m_ready_i;
    n_d = n_q; s_d = s_q; i_d = i_q; prev_d = prev_q; val_d = val_q; k_d = k_q;
    d_d = d_q; top_d = top_q; sec_d = sec_q; thd_d = thd_q; s1_d = s1_q;
    p_d = p_q; r1_d = r1_q; r2_d = r2_q; v_d = v_q; bud_d = bud_q;
    sx_d = sx_q; sy_d = sy_q; ax_d = ax_q; ay_d = ay_q; bx_d = bx_q; by_d = by_q;
    y0_d = y0_q; e1_d = e1_q; e2_d = e2_q; e3_d = e3_q; e4_d = e4_q;
    m1_d = m1_q; m2_d = m2_q; lt_d = lt_q;
    rx_d = rx_q; ry_d = ry_q; rnum_d = rnum_q; rdull_d = rdull_q; rst_d = rst_q;
    oc_d = oc_q; ox_d = ox_q; oy_d = oy_q; on_d = on_q; odull_d = odull_q; ost_d = ost_q;
    vwe = 1'b0; vwa = '0; vwx = '0; vwy = '0; vra = '0;
    hwe = 1'b0; hwa = '0; hwd = '0; hra = '0;
    q_ready_o = 1'b0;
    case (state_q)
      scvh_pkg::S_IDLE: begin
        if (q_valid_i) begin
          q_ready_o = 1'b1;
          rx_d = '0; ry_d = '0; rnum_d = '0; rdull_d = 1'b0; rst_d = scvh_pkg::STAT_OK;
          if (q_kind_i == scvh_pkg::OP_READ) begin
            if (q_pos_i >= hdepth_q) begin
              rst_d   = scvh_pkg::STAT_RANGE;
              state_d = scvh_pkg::S_OUT;
            end else begin
              hra     = KAW'(q_pos_i);
              state_d = scvh_pkg::S_RD1;
            end
          end else begin
            if (cnt_q < IW'(MAX_VERTICES)) begin
              vwe   = 1'b1;
              vwa   = SAW'(cnt_q);
              vwx   = q_x_i;
              vwy   = YW'($signed(q_y_i));
              cnt_d = cnt_q + IW'(1);
            end else begin
              rst_d = scvh_pkg::STAT_OVF;
            end
            state_d = (q_kind_i == scvh_pkg::OP_WALK) ? scvh_pkg::S_W0 : scvh_pkg::S_OUT;
          end
        end
      end
      // Hull read: stack entry, then its vertex
      scvh_pkg::S_RD1: begin
        v_d     = hrd_q;
        vra     = SAW'(hrd_q);
        state_d = scvh_pkg::S_RD2;
      end
      scvh_pkg::S_RD2: begin
        rx_d    = vrd_x_q;
        ry_d    = vrd_y_q;
        rnum_d  = v_q;
        rdull_d = dull_q && (v_q == start_q);
        state_d = scvh_pkg::S_OUT;
      end
      // Walk set-up
      scvh_pkg::S_W0: begin
        n_d = cnt_q; cnt_d = '0; hdepth_d = '0; dull_d = 1'b0; start_d = '0;
        if (cnt_q < IW'(3)) begin
          rst_d   = scvh_pkg::STAT_SHORT;
          state_d = scvh_pkg::S_OUT;
        end else begin
          vra     = '0;
          state_d = scvh_pkg::S_MIN0;
        end
      end
      scvh_pkg::S_MIN0: begin
        s_d = '0; sx_d = vrd_x_q; sy_d = vrd_y_q; i_d = IW'(1);
        vra     = SAW'(1);
        state_d = scvh_pkg::S_MIN;
      end
      // Leftmost-then-lowest search
      scvh_pkg::S_MIN: begin
        if (vrd_x_q < sx_q || (vrd_x_q == sx_q && vrd_y_q < sy_q)) begin
          s_d = i_q; sx_d = vrd_x_q; sy_d = vrd_y_q;
        end
        if (i_q == n_q - IW'(1)) begin
          state_d = scvh_pkg::S_PRV0;
        end else begin
          i_d = i_q + IW'(1);
          vra = SAW'(i_q + IW'(1));
        end
      end
      scvh_pkg::S_PRV0: begin
        prev_d  = idx_dec(s_q, n_q);
        vra     = SAW'(idx_dec(s_q, n_q));
        y0_d    = DW'(sy_q) + DW'($signed({1'b0, tol_i, 1'b0}));
        state_d = scvh_pkg::S_PRV1;
      end
      scvh_pkg::S_PRV1: begin
        if (adif > DW'($signed({1'b0, tol_i}))) begin
          i_d     = n_q - IW'(1);
          state_d = scvh_pkg::S_MV_RD;
        end else begin
          s_d = prev_q; val_d = prev_q; k_d = '0;
          state_d = scvh_pkg::S_INIT;
        end
      end
      // Shift the tail up one place for the dull point
      scvh_pkg::S_MV_RD: begin
        vra     = SAW'(i_q);
        state_d = scvh_pkg::S_MV_WR;
      end
      scvh_pkg::S_MV_WR: begin
        vwe = 1'b1; vwa = SAW'(i_q + IW'(1)); vwx = vrd_x_q; vwy = vrd_y_q;
        if (i_q == s_q) begin
          state_d = scvh_pkg::S_DULL;
        end else begin
          i_d     = i_q - IW'(1);
          state_d = scvh_pkg::S_MV_RD;
        end
      end
      scvh_pkg::S_DULL: begin
        vwe = 1'b1; vwa = SAW'(s_q); vwx = sx_q; vwy = YW'(y0_q);
        n_d = n_q + IW'(1); dull_d = 1'b1; val_d = s_q; k_d = '0;
        state_d = scvh_pkg::S_INIT;
      end
      // Seed the stack with four consecutive indices
      scvh_pkg::S_INIT: begin
        start_d = s_q;
        hwe = 1'b1; hwa = KAW'(k_q); hwd = val_q;
        val_d = idx_inc(val_q, n_q);
        k_d   = k_q + 2'd1;
        case (k_q)
          2'd1: begin s1_d = val_q; thd_d = val_q; end
          2'd2: sec_d = val_q;
          2'd3: begin
            top_d   = val_q;
            d_d     = IW'(4);
            bud_d   = BW'({n_q, 1'b0}) + BW'(n_q) + BW'(8);
            state_d = scvh_pkg::S_CHK;
          end
          default: ;
        endcase
      end
      scvh_pkg::S_CHK: begin
        state_d = (top_q == s1_q) ? scvh_pkg::S_FIN : scvh_pkg::S_P1;
      end
      // Drop entries that do not turn left
      scvh_pkg::S_P1: begin
        if (d_q >= IW'(3)) begin
          p_d = thd_q; r1_d = sec_q; r2_d = top_q; ret_d = scvh_pkg::S_P1R;
          state_d = scvh_pkg::S_LA;
        end else begin
          state_d = scvh_pkg::S_B;
        end
      end
      scvh_pkg::S_P1R: begin
        if (!lt_q) begin
          pret_d  = scvh_pkg::S_P1;
          state_d = scvh_pkg::S_POP;
        end else begin
          state_d = scvh_pkg::S_B;
        end
      end
      // Pop the second entry, keep the top
      scvh_pkg::S_POP: begin
        hwe = 1'b1; hwa = KAW'(d_q - IW'(2)); hwd = top_q;
        if (d_q - IW'(2) == IW'(1)) s1_d = top_q;
        d_d   = d_q - IW'(1);
        sec_d = thd_q;
        if (d_q >= IW'(4)) begin
          hra     = KAW'(d_q - IW'(4));
          state_d = scvh_pkg::S_POPW;
        end else begin
          state_d = pret_q;
        end
      end
      scvh_pkg::S_POPW: begin
        thd_d   = hrd_q;
        state_d = pret_q;
      end
      scvh_pkg::S_B: begin
        if (bud_q == '0) begin
          state_d = scvh_pkg::S_FIN;
        end else begin
          bud_d = bud_q - BW'(1);
          p_d = sec_dec; r1_d = sec_q; r2_d = top_q; ret_d = scvh_pkg::S_BR;
          state_d = scvh_pkg::S_LA;
        end
      end
      scvh_pkg::S_BR: begin
        if (lt_q) begin
          if (d_q >= IW'(KD)) begin
            state_d = scvh_pkg::S_FIN;
          end else begin
            hwe = 1'b1; hwa = KAW'(d_q); hwd = top_inc;
            thd_d = sec_q; sec_d = top_q; top_d = top_inc;
            d_d = d_q + IW'(1);
            state_d = scvh_pkg::S_CHK;
          end
        end else begin
          hwe = 1'b1; hwa = KAW'(d_q - IW'(1)); hwd = top_inc;
          if (d_q - IW'(1) == IW'(1)) s1_d = top_inc;
          top_d   = top_inc;
          state_d = scvh_pkg::S_C;
        end
      end
      // Advance the top while it still turns left
      scvh_pkg::S_C: begin
        if (d_q >= IW'(3)) begin
          p_d = thd_q; r1_d = sec_q; r2_d = top_q; ret_d = scvh_pkg::S_CR;
          state_d = scvh_pkg::S_LA;
        end else begin
          state_d = scvh_pkg::S_D;
        end
      end
      scvh_pkg::S_CR: begin
        if (lt_q) begin
          if (bud_q == '0) begin
            state_d = scvh_pkg::S_FIN;
          end else begin
            bud_d = bud_q - BW'(1);
            hwe = 1'b1; hwa = KAW'(d_q - IW'(1)); hwd = top_inc;
            if (d_q - IW'(1) == IW'(1)) s1_d = top_inc;
            top_d   = top_inc;
            state_d = scvh_pkg::S_C;
          end
        end else begin
          state_d = scvh_pkg::S_D;
        end
      end
      scvh_pkg::S_D: begin
        if (d_q >= IW'(3)) begin
          pret_d  = scvh_pkg::S_CHK;
          state_d = scvh_pkg::S_POP;
        end else begin
          state_d = scvh_pkg::S_CHK;
        end
      end
      scvh_pkg::S_FIN: begin
        hdepth_d = (d_q >= IW'(2)) ? d_q - IW'(2) : '0;
        state_d  = scvh_pkg::S_OUT;
      end
      // Turn test: fetch three vertices, multiply, compare
      scvh_pkg::S_LA: begin
        vra     = SAW'(p_q);
        state_d = scvh_pkg::S_LB;
      end
      scvh_pkg::S_LB: begin
        ax_d = vrd_x_q; ay_d = vrd_y_q;
        vra     = SAW'(r1_q);
        state_d = scvh_pkg::S_LC;
      end
      scvh_pkg::S_LC: begin
        bx_d = vrd_x_q; by_d = vrd_y_q;
        vra     = SAW'(r2_q);
        state_d = scvh_pkg::S_LD;
      end
      scvh_pkg::S_LD: begin
        e1_d = EW'(bx_q) - EW'(ax_q);
        e2_d = EW'(vrd_y_q) - EW'(ay_q);
        e3_d = EW'(by_q) - EW'(ay_q);
        e4_d = EW'(vrd_x_q) - EW'(ax_q);
        state_d = scvh_pkg::S_LM;
      end
      scvh_pkg::S_LM: begin
        m1_d = e1_q * e2_q;
        m2_d = e3_q * e4_q;
        state_d = scvh_pkg::S_LE;
      end
      scvh_pkg::S_LE: begin
        lt_d    = (m1_q > m2_q);
        state_d = ret_q;
      end
      // Hand the result to the output register
      scvh_pkg::S_OUT: begin
        if (!ov_q || m_ready_i) begin
          ov_d = 1'b1;
          oc_d = hdepth_q; ox_d = rx_q; oy_d = ry_q; on_d = rnum_q;
          odull_d = rdull_q; ost_d = rst_q;
          state_d = scvh_pkg::S_IDLE;
        end
      end
      default: state_d = scvh_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= scvh_pkg::S_IDLE;
      cnt_q    <= '0;
      hdepth_q <= '0;
      start_q  <= '0;
      dull_q   <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      hdepth_q <= hdepth_d;
      start_q  <= start_d;
      dull_q   <= dull_d;
      ov_q     <= ov_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    ret_q <= ret_d; pret_q <= pret_d;
    n_q <= n_d; s_q <= s_d; i_q <= i_d; prev_q <= prev_d; val_q <= val_d; k_q <= k_d;
    d_q <= d_d; top_q <= top_d; sec_q <= sec_d; thd_q <= thd_d; s1_q <= s1_d;
    p_q <= p_d; r1_q <= r1_d; r2_q <= r2_d; v_q <= v_d; bud_q <= bud_d;
    sx_q <= sx_d; sy_q <= sy_d; ax_q <= ax_d; ay_q <= ay_d; bx_q <= bx_d; by_q <= by_d;
    y0_q <= y0_d; e1_q <= e1_d; e2_q <= e2_d; e3_q <= e3_d; e4_q <= e4_d;
    m1_q <= m1_d; m2_q <= m2_d; lt_q <= lt_d;
    rx_q <= rx_d; ry_q <= ry_d; rnum_q <= rnum_d; rdull_q <= rdull_d; rst_q <= rst_d;
    oc_q <= oc_d; ox_q <= ox_d; oy_q <= oy_d; on_q <= on_d; odull_q <= odull_d;
    ost_q <= ost_d;
  end

  // Vertex store
  always_ff @(posedge clk_i) begin
    if (vwe) begin
      vx_mem[vwa] <= vwx;
      vy_mem[vwa] <= vwy;
    end
    vrd_x_q <= vx_mem[vra];
    vrd_y_q <= vy_mem[vra];
  end

  // Hull stack
  always_ff @(posedge clk_i) begin
    if (hwe) hmem[hwa] <= hwd;
    hrd_q <= hmem[hra];
  end

endmodule

// File: rtl/simple_polygon_convex_hull.sv
// ----------------------------------------------------------------------------
// simple_polygon_convex_hull
// Convex hull of a simple polygon by a linear stack walk, with stream ports
// and an APB register for the dull point tolerance.
// ----------------------------------------------------------------------------
// A load beat passes through the idle and output states of the back end
// sequencer and a read beat through idle, both read states and output (idle
// and output alone when the position is beyond the hull count), with the
// vertex and stack memories read through registered ports; a two-entry queue
// lets beats arrive while the back end works, and a result held by a stalled
// master side keeps the back end in its output state. The beat flagged last
// runs the walk: a leftmost search over the n vertices, a read and a write per
// vertex moved for the dull point, four indices to seed the stack, then turn
// tests (issue, three vertex reads, differences, multiply, compare, return)
// with one or two tests for each of at most 3n+8 advances, plus the pops.
module simple_polygon_convex_hull #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // vertex_x, vertex_y, read_position (low bit up), zero fill
  input  logic [((2*COORD_BITS+$clog2(MAX_VERTICES+5)+7)/8)*8-1:0] s_axis_tdata,
  input  logic                s_axis_tlast,   // last_vertex
  input  logic                s_axis_tuser,   // mode
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // hull_count, hull_x, hull_y, vertex_number (low bit up), zero fill
  output logic [((2*COORD_BITS+2*$clog2(MAX_VERTICES+5)+1+7)/8)*8-1:0] m_axis_tdata,
  output logic [2:0]          m_axis_tuser    // is_dull_point, status
);

  localparam int CW  = COORD_BITS;
  localparam int IW  = $clog2(MAX_VERTICES + 5);
  localparam int TDO = ((2*CW + 2*IW + 1 + 7) / 8) * 8;
  localparam int USED = 2*CW + 2*IW + 1;

  logic [9:0]         tol_q;
  logic               q_valid, q_ready;
  scvh_pkg::scvh_op_e q_kind;
  logic [CW-1:0]      q_x, q_y;
  logic [IW-1:0]      q_pos;
  logic [IW-1:0]      m_count, m_num;
  logic [CW-1:0]      m_x;
  logic [CW:0]        m_y;
  logic               m_dull;
  logic [1:0]         m_status;

  // Register access
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {22'd0, tol_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= 10'd1;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      tol_q <= pwdata[9:0];
    end
  end

  scvh_front #(.CW(CW), .IW(IW)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_mode_i  (s_axis_tuser),
    .s_last_i  (s_axis_tlast),
    .s_x_i     (s_axis_tdata[CW-1:0]),
    .s_y_i     (s_axis_tdata[2*CW-1:CW]),
    .s_pos_i   (s_axis_tdata[2*CW+IW-1:2*CW]),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_kind_o  (q_kind),
    .q_x_o     (q_x),
    .q_y_o     (q_y),
    .q_pos_o   (q_pos)
  );

  scvh_back #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS), .IW(IW)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tol_i      (tol_q),
    .q_valid_i  (q_valid),
    .q_ready_o  (q_ready),
    .q_kind_i   (q_kind),
    .q_x_i      (q_x),
    .q_y_i      (q_y),
    .q_pos_i    (q_pos),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_count_o  (m_count),
    .m_x_o      (m_x),
    .m_y_o      (m_y),
    .m_num_o    (m_num),
    .m_dull_o   (m_dull),
    .m_status_o (m_status)
  );

  // Pack the result beat
  assign m_axis_tdata = TDO'({m_num, m_y, m_x, m_count}) & {{(TDO-USED){1'b0}}, {USED{1'b1}}};
  assign m_axis_tuser = {m_status, m_dull};

endmodule
